>>> rtl/i2crts_pkg.sv
// Shared types and codes for the I2C register transaction sequencer.
package i2crts_pkg;

  localparam logic       CMD_REQUEST = 1'b0;
  localparam logic       CMD_POLL    = 1'b1;

  localparam logic [1:0] KIND_READ1  = 2'd0;
  localparam logic [1:0] KIND_READN  = 2'd1;
  localparam logic [1:0] KIND_WRITE1 = 2'd2;
  localparam logic [1:0] KIND_BAD    = 2'd3;

  localparam int FLAG_SB    = 0;
  localparam int FLAG_ADDR  = 1;
  localparam int FLAG_TXE   = 2;
  localparam int FLAG_RXNE  = 3;
  localparam int FLAG_BTF   = 4;
  localparam int FLAG_BUSY  = 5;
  localparam int FLAG_STOPP = 6;
  localparam int FLAG_ARLO  = 7;
  localparam int FLAG_BERR  = 8;
  localparam int FLAG_AF    = 9;

  localparam logic [3:0] ACT_NONE      = 4'd0;
  localparam logic [3:0] ACT_START     = 4'd1;
  localparam logic [3:0] ACT_WRITE     = 4'd2;
  localparam logic [3:0] ACT_STOP      = 4'd3;
  localparam logic [3:0] ACT_SET_ACK   = 4'd4;
  localparam logic [3:0] ACT_CLR_ACK   = 4'd5;
  localparam logic [3:0] ACT_CLR_ADDR  = 4'd6;
  localparam logic [3:0] ACT_STORE     = 4'd7;
  localparam logic [3:0] ACT_CLR_ERR   = 4'd8;
  localparam logic [3:0] ACT_FINISHED  = 4'd9;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_TIMEOUT = 3'd1;
  localparam logic [2:0] ST_ARLO    = 3'd2;
  localparam logic [2:0] ST_BERR    = 3'd3;
  localparam logic [2:0] ST_NACK    = 3'd4;
  localparam logic [2:0] ST_INVALID = 3'd5;
  localparam logic [2:0] ST_RECFAIL = 3'd6;

  localparam logic [7:0] TIMEOUT_RESET = 8'd10;
  localparam logic [7:0] MIN_MULTI_LEN = 8'd3;
  localparam int         MAX_RESULTS   = 4;

  typedef struct packed {
    logic       cmd;
    logic [1:0] transfer_kind;
    logic [6:0] target_address;
    logic [7:0] reg_address;
    logic [7:0] write_value;
    logic [7:0] read_length;
    logic [9:0] status_flags;
    logic [7:0] data_register;
    logic       ms_tick;
  } item_t;

  typedef struct packed {
    logic [3:0] action;
    logic [7:0] action_data;
    logic [7:0] read_index;
    logic [2:0] final_status;
  } result_t;

  typedef struct packed {
    logic [2:0]                  cnt;
    result_t [MAX_RESULTS-1:0]   res;
  } bundle_t;

endpackage

>>> rtl/i2crts_core.sv
// Transaction state and the per-item decision logic of the sequencer.
module i2crts_core (
  input  logic                    clk,
  input  logic                    rst,
  input  i2crts_pkg::item_t       item,
  input  logic                    go,
  input  logic                    cfg_we,
  input  logic [7:0]              cfg_value,
  output i2crts_pkg::bundle_t     bundle
);

  typedef enum logic [3:0] {
    P_IDLE, P_BUSY, P_SB1, P_ADDR1, P_TXE_REG, P_BTF1, P_SB2, P_ADDR2,
    P_RX_LOOP, P_BTF2, P_DR2, P_RX_LAST, P_TXE_VAL, P_BTF_W, P_STOP, P_RECOV
  } phase_t;

  phase_t     phase, phase_next;
  logic [7:0] timeout_limit;
  logic [1:0] kind_held, kind_held_next;
  logic [6:0] target_held, target_held_next;
  logic [7:0] register_held, register_held_next;
  logic [7:0] value_held, value_held_next;
  logic [7:0] length_held, length_held_next;
  logic [7:0] byte_counter, byte_counter_next;
  logic [7:0] elapsed_ms, elapsed_ms_next;
  logic [2:0] pending_status, pending_status_next;

  logic [9:0] f;
  logic [7:0] dr;
  logic [7:0] el;
  logic       tmo;
  logic [2:0] err;
  logic       do_adv, do_abort, do_finish;
  logic [2:0] ab_st, fin_st;
  logic [9:0] fin_f;
  logic       awaited_set;
  logic [2:0] n;
  logic       more_loop;

  function automatic i2crts_pkg::result_t mk(logic [3:0] a, logic [7:0] d,
                                             logic [7:0] i, logic [2:0] s);
    i2crts_pkg::result_t r;
    r.action       = a;
    r.action_data  = d;
    r.read_index   = i;
    r.final_status = s;
    return r;
  endfunction

  assign f  = item.status_flags;
  assign dr = item.data_register;

  always_comb begin
    phase_next          = phase;
    kind_held_next      = kind_held;
    target_held_next    = target_held;
    register_held_next  = register_held;
    value_held_next     = value_held;
    length_held_next    = length_held;
    byte_counter_next   = byte_counter;
    elapsed_ms_next     = elapsed_ms;
    pending_status_next = pending_status;
    bundle              = '0;
    n                   = 3'd0;
    do_adv              = 1'b0;
    do_abort            = 1'b0;
    do_finish           = 1'b0;
    ab_st               = i2crts_pkg::ST_OK;
    fin_st              = i2crts_pkg::ST_OK;
    fin_f               = f;
    el                  = elapsed_ms;
    if (item.ms_tick && elapsed_ms != 8'hFF) begin
      el = elapsed_ms + 8'd1;
    end
    tmo = (el >= timeout_limit);

    if (f[i2crts_pkg::FLAG_ARLO]) begin
      err = i2crts_pkg::ST_ARLO;
    end else if (f[i2crts_pkg::FLAG_BERR]) begin
      err = i2crts_pkg::ST_BERR;
    end else if (f[i2crts_pkg::FLAG_AF]) begin
      err = i2crts_pkg::ST_NACK;
    end else begin
      err = i2crts_pkg::ST_OK;
    end

    case (phase)
      P_SB1, P_SB2:                 awaited_set = f[i2crts_pkg::FLAG_SB];
      P_ADDR1, P_ADDR2:             awaited_set = f[i2crts_pkg::FLAG_ADDR];
      P_TXE_REG, P_TXE_VAL:         awaited_set = f[i2crts_pkg::FLAG_TXE];
      P_BTF1, P_BTF2, P_BTF_W:      awaited_set = f[i2crts_pkg::FLAG_BTF];
      default:                      awaited_set = f[i2crts_pkg::FLAG_RXNE];
    endcase

    if (item.cmd == i2crts_pkg::CMD_REQUEST) begin
      if (phase == P_IDLE) begin
        kind_held_next      = item.transfer_kind;
        target_held_next    = item.target_address;
        register_held_next  = item.reg_address;
        value_held_next     = item.write_value;
        length_held_next    = item.read_length;
        byte_counter_next   = 8'd0;
        elapsed_ms_next     = 8'd0;
        pending_status_next = i2crts_pkg::ST_OK;
        if (item.transfer_kind == i2crts_pkg::KIND_BAD ||
            (item.transfer_kind == i2crts_pkg::KIND_READN &&
             item.read_length < i2crts_pkg::MIN_MULTI_LEN)) begin
          bundle.res[0] = mk(i2crts_pkg::ACT_FINISHED, 8'd0, 8'd0,
                             i2crts_pkg::ST_INVALID);
          n = 3'd1;
        end else begin
          phase_next = P_BUSY;
        end
      end
    end else if (phase != P_IDLE) begin
      elapsed_ms_next = el;
      case (phase)
        P_STOP: begin
          if (!f[i2crts_pkg::FLAG_STOPP]) begin
            do_finish = 1'b1;
            fin_f     = 10'd0;
            fin_st    = i2crts_pkg::ST_OK;
          end else if (tmo) begin
            do_abort = 1'b1;
            ab_st    = i2crts_pkg::ST_TIMEOUT;
          end
        end
        P_RECOV: begin
          if (!f[i2crts_pkg::FLAG_STOPP]) begin
            do_finish = 1'b1;
            fin_st    = pending_status;
          end else if (tmo) begin
            do_finish = 1'b1;
            fin_st    = i2crts_pkg::ST_RECFAIL;
          end
        end
        P_DR2: begin
          bundle.res[0] = mk(i2crts_pkg::ACT_STORE, dr, byte_counter, i2crts_pkg::ST_OK);
          n          = 3'd1;
          phase_next = P_RX_LAST;
        end
        default: begin
          if (err != i2crts_pkg::ST_OK || tmo) begin
            // Errors take priority over the timeout.
            ab_st = (err != i2crts_pkg::ST_OK) ? err : i2crts_pkg::ST_TIMEOUT;
            if (phase == P_BUSY) begin
              phase_next    = P_IDLE;
              bundle.res[0] = mk(i2crts_pkg::ACT_FINISHED, 8'd0, 8'd0, ab_st);
              n             = 3'd1;
            end else begin
              do_abort = 1'b1;
            end
          end else if (phase == P_BUSY) begin
            do_adv = !f[i2crts_pkg::FLAG_BUSY];
          end else begin
            do_adv = awaited_set;
          end
        end
      endcase
    end

    if (do_abort) begin
      if (!f[i2crts_pkg::FLAG_ARLO] &&
          (f[i2crts_pkg::FLAG_BERR] || f[i2crts_pkg::FLAG_AF] ||
           ab_st == i2crts_pkg::ST_TIMEOUT)) begin
        pending_status_next = ab_st;
        elapsed_ms_next     = 8'd0;
        phase_next          = P_RECOV;
        bundle.res[0] = mk(i2crts_pkg::ACT_STOP, 8'd0, 8'd0, i2crts_pkg::ST_OK);
        n = 3'd1;
      end else begin
        do_finish = 1'b1;
        fin_st    = ab_st;
      end
    end

    if (do_finish) begin
      if (fin_f[i2crts_pkg::FLAG_ARLO] || fin_f[i2crts_pkg::FLAG_BERR] ||
          fin_f[i2crts_pkg::FLAG_AF]) begin
        bundle.res[n[1:0]] = mk(i2crts_pkg::ACT_CLR_ERR, 8'd0, 8'd0, i2crts_pkg::ST_OK);
        n = n + 3'd1;
      end
      bundle.res[n[1:0]] = mk(i2crts_pkg::ACT_FINISHED, 8'd0, 8'd0, fin_st);
      n = n + 3'd1;
      phase_next = P_IDLE;
    end

    more_loop = ({1'b0, byte_counter_next} + 9'd3) < {1'b0, length_held};

    if (do_adv) begin
      case (phase)
        P_BUSY: begin
          if (kind_held != i2crts_pkg::KIND_WRITE1) begin
            bundle.res[0] = mk(i2crts_pkg::ACT_SET_ACK, 8'd0, 8'd0, i2crts_pkg::ST_OK);
            n = 3'd1;
          end
          bundle.res[n[1:0]] = mk(i2crts_pkg::ACT_START, 8'd0, 8'd0, i2crts_pkg::ST_OK);
          n = n + 3'd1;
          phase_next = P_SB1;
        end
        P_SB1: begin
          bundle.res[0] = mk(i2crts_pkg::ACT_WRITE, {target_held, 1'b0}, 8'd0,
                             i2crts_pkg::ST_OK);
          n = 3'd1;
          phase_next = P_ADDR1;
        end
        P_ADDR1: begin
          bundle.res[0] = mk(i2crts_pkg::ACT_CLR_ADDR, 8'd0, 8'd0, i2crts_pkg::ST_OK);
          n = 3'd1;
          phase_next = P_TXE_REG;
        end
        P_TXE_REG: begin
          bundle.res[0] = mk(i2crts_pkg::ACT_WRITE, register_held, 8'd0, i2crts_pkg::ST_OK);
          n = 3'd1;
          phase_next = (kind_held == i2crts_pkg::KIND_WRITE1) ? P_TXE_VAL : P_BTF1;
        end
        P_BTF1: begin
          bundle.res[0] = mk(i2crts_pkg::ACT_START, 8'd0, 8'd0, i2crts_pkg::ST_OK);
          n = 3'd1;
          phase_next = P_SB2;
        end
        P_SB2: begin
          bundle.res[0] = mk(i2crts_pkg::ACT_WRITE, {target_held, 1'b1}, 8'd0,
                             i2crts_pkg::ST_OK);
          n = 3'd1;
          phase_next = P_ADDR2;
        end
        P_ADDR2: begin
          if (kind_held == i2crts_pkg::KIND_READ1) begin
            bundle.res[0] = mk(i2crts_pkg::ACT_CLR_ACK, 8'd0, 8'd0, i2crts_pkg::ST_OK);
            bundle.res[1] = mk(i2crts_pkg::ACT_CLR_ADDR, 8'd0, 8'd0, i2crts_pkg::ST_OK);
            bundle.res[2] = mk(i2crts_pkg::ACT_STOP, 8'd0, 8'd0, i2crts_pkg::ST_OK);
            n = 3'd3;
            phase_next = P_RX_LAST;
          end else begin
            bundle.res[0] = mk(i2crts_pkg::ACT_CLR_ADDR, 8'd0, 8'd0, i2crts_pkg::ST_OK);
            n = 3'd1;
            phase_next = more_loop ? P_RX_LOOP : P_BTF2;
          end
        end
        P_RX_LOOP: begin
          bundle.res[0] = mk(i2crts_pkg::ACT_STORE, dr, byte_counter, i2crts_pkg::ST_OK);
          n = 3'd1;
          byte_counter_next = byte_counter + 8'd1;
          // Recomputed against the incremented counter.
          phase_next = (({1'b0, byte_counter} + 9'd4) < {1'b0, length_held}) ?
                       P_RX_LOOP : P_BTF2;
        end
        P_BTF2: begin
          bundle.res[0] = mk(i2crts_pkg::ACT_CLR_ACK, 8'd0, 8'd0, i2crts_pkg::ST_OK);
          bundle.res[1] = mk(i2crts_pkg::ACT_STORE, dr, byte_counter, i2crts_pkg::ST_OK);
          bundle.res[2] = mk(i2crts_pkg::ACT_STOP, 8'd0, 8'd0, i2crts_pkg::ST_OK);
          n = 3'd3;
          byte_counter_next = byte_counter + 8'd1;
          phase_next = P_DR2;
        end
        P_RX_LAST: begin
          bundle.res[0] = mk(i2crts_pkg::ACT_STORE, dr, byte_counter, i2crts_pkg::ST_OK);
          n = 3'd1;
          phase_next = P_STOP;
        end
        P_TXE_VAL: begin
          bundle.res[0] = mk(i2crts_pkg::ACT_WRITE, value_held, 8'd0, i2crts_pkg::ST_OK);
          n = 3'd1;
          phase_next = P_BTF_W;
        end
        default: begin
          bundle.res[0] = mk(i2crts_pkg::ACT_STOP, 8'd0, 8'd0, i2crts_pkg::ST_OK);
          n = 3'd1;
          phase_next = P_STOP;
        end
      endcase
    end

    bundle.cnt = n;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= P_IDLE;
      timeout_limit  <= i2crts_pkg::TIMEOUT_RESET;
      kind_held      <= 2'd0;
      target_held    <= 7'd0;
      register_held  <= 8'd0;
      value_held     <= 8'd0;
      length_held    <= 8'd0;
      byte_counter   <= 8'd0;
      elapsed_ms     <= 8'd0;
      pending_status <= i2crts_pkg::ST_OK;
    end else begin
      if (cfg_we) begin
        timeout_limit <= cfg_value;
      end
      if (go) begin
        phase          <= phase_next;
        kind_held      <= kind_held_next;
        target_held    <= target_held_next;
        register_held  <= register_held_next;
        value_held     <= value_held_next;
        length_held    <= length_held_next;
        byte_counter   <= byte_counter_next;
        elapsed_ms     <= elapsed_ms_next;
        pending_status <= pending_status_next;
      end
    end
  end

endmodule

>>> rtl/i2crts_outbuf.sv
// Result buffer that hands the actions of one item out one at a time.
module i2crts_outbuf (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  load,
  input  i2crts_pkg::bundle_t   bundle,
  output logic                  can_load,
  output logic                  out_valid,
  input  logic                  out_stall,
  output i2crts_pkg::result_t   res,
  output logic                  last
);

  i2crts_pkg::result_t [i2crts_pkg::MAX_RESULTS-1:0] entries;
  logic [2:0] cnt;
  logic [1:0] ptr;
  logic       take;

  assign out_valid = (cnt != 3'd0);
  assign res       = entries[ptr];
  assign last      = ({1'b0, ptr} == cnt - 3'd1);
  assign take      = out_valid && !out_stall;
  assign can_load  = !out_valid || (take && last);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 3'd0;
      ptr <= 2'd0;
    end else if (load) begin
      cnt <= bundle.cnt;
      ptr <= 2'd0;
    end else if (take) begin
      if (last) begin
        cnt <= 3'd0;
        ptr <= 2'd0;
      end else begin
        ptr <= ptr + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      entries <= bundle.res;
    end
  end

endmodule

>>> rtl/i2c_register_transaction_sequencer.sv
// Top level: input register, decision core and result buffer of the sequencer.
// An accepted item is registered at the input and decided by the core; the result
// buffer registers its actions before the first appears on the output. Throughput:
// one item per cycle while the buffer drains; an item holds the input until the
// actions (up to three) of the one before leave, one per cycle without out_stall.
// Reset (synchronous, rst high) returns to idle with a 10 ms timeout limit.
module i2c_register_transaction_sequencer (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       cmd,
  input  logic [1:0] transfer_kind,
  input  logic [6:0] target_address,
  input  logic [7:0] reg_address,
  input  logic [7:0] write_value,
  input  logic [7:0] read_length,
  input  logic [9:0] status_flags,
  input  logic [7:0] data_register,
  input  logic       ms_tick,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [3:0] action,
  output logic [7:0] action_data,
  output logic [7:0] read_index,
  output logic [2:0] final_status,
  output logic       last_of_run,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_data
);

  i2crts_pkg::item_t   item;
  logic                in_full;
  logic                accept;
  logic                move;
  logic                can_load;
  i2crts_pkg::bundle_t bundle;
  i2crts_pkg::result_t res;

  assign cfg_ready = 1'b1;
  // Items with no actions retire without waiting for the result buffer.
  assign move      = in_full && (bundle.cnt == 3'd0 || can_load);
  assign in_stall  = in_full && !move;
  assign accept    = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (accept) begin
      in_full <= 1'b1;
    end else if (move) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item.cmd            <= cmd;
      item.transfer_kind  <= transfer_kind;
      item.target_address <= target_address;
      item.reg_address    <= reg_address;
      item.write_value    <= write_value;
      item.read_length    <= read_length;
      item.status_flags   <= status_flags;
      item.data_register  <= data_register;
      item.ms_tick        <= ms_tick;
    end
  end

  i2crts_core u_core (
    .clk       (clk),
    .rst       (rst),
    .item      (item),
    .go        (move),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_value (cfg_data),
    .bundle    (bundle)
  );

  i2crts_outbuf u_outbuf (
    .clk       (clk),
    .rst       (rst),
    .load      (move && bundle.cnt != 3'd0),
    .bundle    (bundle),
    .can_load  (can_load),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .res       (res),
    .last      (last_of_run)
  );

  assign action       = res.action;
  assign action_data  = res.action_data;
  assign read_index   = res.read_index;
  assign final_status = res.final_status;

  a_finish_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && action == i2crts_pkg::ACT_FINISHED |-> last_of_run)
    else $error("finished action is not the last of its item");

  a_status_only_on_finish: assert property (@(posedge clk) disable iff (rst)
    out_valid && action != i2crts_pkg::ACT_FINISHED |-> final_status == i2crts_pkg::ST_OK)
    else $error("status reported on an action other than finished");

  a_bundle_fits: assert property (@(posedge clk) disable iff (rst)
    move |-> bundle.cnt <= 3'd4)
    else $error("item produced more actions than the buffer holds");

  a_retire_frees_input: assert property (@(posedge clk) disable iff (rst)
    move && !accept |=> !in_full)
    else $error("input register still full after its item retired");

endmodule
